>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: explicit clock and reset
`define MFP_ASSERT_ON(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Usual form: clk and rst of the enclosing module
`define MFP_ASSERT(lbl, prop, msg) `MFP_ASSERT_ON(lbl, clk, rst, prop, msg)

`endif

>>> hdl/mfp_pkg.sv
// ----------------------------------------------------------------------------
// mfp_pkg
// Types and constants shared by the framebuffer plotter modules.
// ----------------------------------------------------------------------------
package mfp_pkg;

  // Frame geometry
  localparam int BUFFER_BYTES  = 1024;
  localparam int PANEL_COLUMNS = 128;
  localparam int RowsTall      = 64;
  localparam int RowsShort     = 32;

  localparam int AddrW = $clog2(BUFFER_BYTES);
  localparam int ColW  = $clog2(PANEL_COLUMNS);
  localparam int RowW  = $clog2(RowsTall);
  // Width for address arithmetic and range checks (covers all legal geometries)
  localparam int CmpW  = 14;

  localparam logic [AddrW-1:0] SweepLast = AddrW'(BUFFER_BYTES - 1);

  // Command queue depth
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Input opcodes
  typedef enum logic [1:0] {
    OP_PLOT  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_LOAD  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Plot combine modes
  typedef enum logic [1:0] {
    WM_OR   = 2'd0,
    WM_ANDN = 2'd1,
    WM_XOR  = 2'd2,
    WM_SET  = 2'd3
  } wmode_t;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_DROP,
    CMD_PLOT,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_READ
  } cmd_kind_t;

  // One classified item, as passed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [AddrW-1:0]  addr;
    logic [7:0]        data;   // pixel mask for plot, raw byte for load
    wmode_t            mode;
  } cmd_t;

  // Back-end states
  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_IDLE,
    BK_FETCH
  } bk_state_t;

endpackage

>>> hdl/monochrome_framebuffer_plotter_unit.sv
// ----------------------------------------------------------------------------
// monochrome_framebuffer_plotter_unit
// Page-packed monochrome framebuffer with pixel plot, clear, load and read.
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the 1024-byte frame memory
// and takes no item until it ends; configuration writes are taken as ever.
// Items enter a two-entry command queue, so the input side keeps accepting
// until the queue is full while the executing side is busy or the result
// waits. A dropped plot, a load or an out-of-range access is finished as
// the executing side takes it, a plot or a read is fetched from the frame
// memory, then written back or returned, and a clear is taken, then sweeps
// all 1024 bytes. Each item yields exactly one result item, in order.
module monochrome_framebuffer_plotter_unit
  import mfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  input  logic [1:0]         write_mode,
  input  logic [9:0]         byte_index,
  input  logic [7:0]         byte_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         read_value,
  output logic               dropped
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;
  logic init_busy;

  // Front end: accept and classify
  mfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .write_mode (write_mode),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .q_full     (q_full),
    .init_busy  (init_busy),
    .push       (push),
    .cmd        (push_cmd)
  );

  // Command queue
  mfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back end: memory access and result
  mfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .dropped    (dropped)
  );

endmodule

>>> hdl/mfp_front.sv
// ----------------------------------------------------------------------------
// mfp_front
// Accepts items, flips and range-checks plot points, builds the byte mask
// and address, and pushes one classified command per item into the queue.
// ----------------------------------------------------------------------------
module mfp_front
  import mfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic signed [15:0] pixel_x,
  input  logic signed [15:0] pixel_y,
  input  logic [1:0]         write_mode,
  input  logic [9:0]         byte_index,
  input  logic [7:0]         byte_value,
  input  logic               q_full,
  input  logic               init_busy,
  output logic               push,
  output cmd_t               cmd
);

  logic               short_panel;
  logic signed [16:0] sx;
  logic signed [16:0] sy;
  logic signed [16:0] height_s;
  logic signed [16:0] col_s;
  logic signed [16:0] row_s;
  logic               col_ok;
  logic               row_ok;
  logic [RowW-1:0]    r;
  logic [7:0]         bit_mask;
  logic [7:0]         mask;
  logic [CmpW-1:0]    addr_full;
  logic               plot_ok;
  logic               idx_ok;

  // Panel height register
  always_ff @(posedge clk) begin
    if (rst) begin
      short_panel <= 1'b0;
    end else if (cfg_write) begin
      short_panel <= cfg_data;
    end
  end

  // Flip into panel coordinates
  assign sx       = {pixel_x[15], pixel_x};
  assign sy       = {pixel_y[15], pixel_y};
  assign height_s = short_panel ? $signed(17'(RowsShort)) : $signed(17'(RowsTall));
  assign col_s    = $signed(17'(PANEL_COLUMNS)) - sx;
  assign row_s    = height_s - sy;
  assign col_ok   = (col_s >= 17'sd0) && (col_s < $signed(17'(PANEL_COLUMNS)));
  assign row_ok   = (row_s >= 17'sd0) && (row_s < height_s);

  // Short panel: row 2r+1, two adjacent bits
  assign r        = short_panel ? {row_s[RowW-2:0], 1'b1} : row_s[RowW-1:0];
  assign bit_mask = 8'b1 << r[2:0];
  assign mask     = short_panel ? (bit_mask | (bit_mask >> 1)) : bit_mask;

  // Byte address: column plus page times panel width
  assign addr_full = CmpW'(col_s[ColW-1:0]) + CmpW'(r[RowW-1:3]) * CmpW'(PANEL_COLUMNS);
  assign plot_ok   = col_ok && row_ok && (addr_full < CmpW'(BUFFER_BYTES));
  assign idx_ok    = CmpW'(byte_index) < CmpW'(BUFFER_BYTES);

  // Handshake
  assign in_stall = q_full || init_busy;
  assign push     = in_valid && !in_stall;

  // Classification
  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NOP;
    cmd.addr = AddrW'(byte_index);
    cmd.data = byte_value;
    cmd.mode = wmode_t'(write_mode);
    unique case (opcode_t'(opcode))
      OP_PLOT: begin
        if (plot_ok) begin
          cmd.kind = CMD_PLOT;
          cmd.addr = AddrW'(addr_full);
          cmd.data = mask;
        end else begin
          cmd.kind = CMD_DROP;
        end
      end
      OP_CLEAR: begin
        cmd.kind = CMD_CLEAR;
      end
      OP_LOAD: begin
        cmd.kind = idx_ok ? CMD_LOAD : CMD_NOP;
      end
      OP_READ: begin
        cmd.kind = idx_ok ? CMD_READ : CMD_NOP;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

endmodule

>>> hdl/mfp_queue.sv
// ----------------------------------------------------------------------------
// mfp_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfp_queue
  import mfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              slots [QDepth];
  logic [QPtrW-1:0]  wptr;
  logic [QPtrW-1:0]  rptr;
  logic [QCntW-1:0]  count;
  logic [QPtrW-1:0]  wptr_next;
  logic [QPtrW-1:0]  rptr_next;

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rptr];

  // Pointer wrap
  assign wptr_next = (wptr == QPtrW'(QDepth - 1)) ? '0 : wptr + 1'b1;
  assign rptr_next = (rptr == QPtrW'(QDepth - 1)) ? '0 : rptr + 1'b1;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr_next;
      end
      if (pop) begin
        rptr <= rptr_next;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MFP_ASSERT(a_no_push_full, !(push && full), "queue pushed while full")
  `MFP_ASSERT(a_no_pop_empty, pop |-> head_valid, "queue popped while empty")

endmodule

>>> hdl/mfp_back.sv
// ----------------------------------------------------------------------------
// mfp_back
// Executes queued commands on the frame memory: clearing sweeps, raw loads,
// byte reads and read-modify-write pixel plots, and holds the result item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfp_back
  import mfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_value,
  output logic       dropped
);

  logic [7:0]        frame_store [BUFFER_BYTES];
  logic [7:0]        rdata;

  bk_state_t         state;
  bk_state_t         state_next;
  logic [AddrW-1:0]  sweep_cnt;
  logic [AddrW-1:0]  sweep_cnt_next;
  logic              clear_pend;
  logic              clear_pend_next;
  cmd_t              cur;
  cmd_t              cur_next;

  logic              slot_free;
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AddrW-1:0]  mem_raddr;
  logic              load_out;
  logic [7:0]        rv_next;
  logic              drop_next;
  logic [7:0]        plot_byte;

  // Frame memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= frame_store[mem_raddr];
    end
  end

  // Combine mask with fetched byte
  always_comb begin
    unique case (cur.mode)
      WM_OR:   plot_byte = rdata | cur.data;
      WM_ANDN: plot_byte = rdata & ~cur.data;
      WM_XOR:  plot_byte = rdata ^ cur.data;
      WM_SET:  plot_byte = cur.data;
      default: plot_byte = cur.data;
    endcase
  end

  assign slot_free = !out_valid || !out_stall;
  assign init_busy = (state == BK_SWEEP) && !clear_pend;

  // State register and work registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_SWEEP;
      sweep_cnt  <= '0;
      clear_pend <= 1'b0;
    end else begin
      state      <= state_next;
      sweep_cnt  <= sweep_cnt_next;
      clear_pend <= clear_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    sweep_cnt_next  = sweep_cnt;
    clear_pend_next = clear_pend;
    cur_next        = cur;
    pop             = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = head_cmd.addr;
    mem_wdata       = head_cmd.data;
    mem_re          = 1'b0;
    mem_raddr       = head_cmd.addr;
    load_out        = 1'b0;
    rv_next         = 8'd0;
    drop_next       = 1'b0;
    unique case (state)
      BK_SWEEP: begin
        mem_we         = 1'b1;
        mem_waddr      = sweep_cnt;
        mem_wdata      = 8'd0;
        sweep_cnt_next = sweep_cnt + 1'b1;
        if (sweep_cnt == SweepLast) begin
          sweep_cnt_next  = '0;
          state_next      = BK_IDLE;
          clear_pend_next = 1'b0;
          // a clear command reports once its sweep is done
          load_out        = clear_pend;
        end
      end
      BK_IDLE: begin
        if (head_valid && slot_free) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            CMD_PLOT, CMD_READ: begin
              mem_re     = 1'b1;
              cur_next   = head_cmd;
              state_next = BK_FETCH;
            end
            CMD_CLEAR: begin
              clear_pend_next = 1'b1;
              state_next      = BK_SWEEP;
            end
            CMD_LOAD: begin
              mem_we   = 1'b1;
              load_out = 1'b1;
            end
            CMD_DROP: begin
              load_out  = 1'b1;
              drop_next = 1'b1;
            end
            CMD_NOP: begin
              load_out = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      BK_FETCH: begin
        load_out   = 1'b1;
        state_next = BK_IDLE;
        if (cur.kind == CMD_READ) begin
          rv_next = rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur.addr;
          mem_wdata = plot_byte;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      read_value <= rv_next;
      dropped    <= drop_next;
    end
  end

  `MFP_ASSERT(a_fetch_slot_empty, (state == BK_FETCH) |-> !out_valid, "result slot busy in fetch")
  `MFP_ASSERT(a_drop_no_data, (out_valid && dropped) |-> (read_value == 8'd0), "dropped item with data")

endmodule
